[sv/mssp_pkg.sv]
package mssp_pkg;

    // Parse phases of the section walker
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_VCOUNT  = 4'd1,
        PH_VERT    = 4'd2,
        PH_FCOUNT  = 4'd3,
        PH_FHEAD   = 4'd4,
        PH_CORNER  = 4'd5,
        PH_NPCOUNT = 4'd6,
        PH_NPNAME  = 4'd7,
        PH_NPVALS  = 4'd8
    } phase_t;

    // Record kinds on the output channel
    localparam logic [2:0] KIND_VERTEX = 3'd0;
    localparam logic [2:0] KIND_FACE   = 3'd1;
    localparam logic [2:0] KIND_CORNER = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;
    localparam logic [2:0] KIND_BADIDX = 3'd4;
    localparam logic [2:0] KIND_TRUNC  = 3'd5;

    // Byte positions that close a field group
    localparam logic [3:0] POS_X_LAST      = 4'd3;
    localparam logic [3:0] POS_Y_LAST      = 4'd7;
    localparam logic [3:0] POS_CORNER_LAST = 4'd9;
    localparam logic [3:0] POS_VALS_LAST   = 4'd11;
    localparam logic [3:0] POS_FHEAD_LAST  = 4'd3;

    // Parser state carried from item to item
    typedef struct packed {
        phase_t      phase;
        logic [3:0]  byte_position;
        logic [31:0] assembly_word;
        logic [31:0] held_x;
        logic [31:0] held_y;
        logic [15:0] vertex_count;
        logic [15:0] items_left;
        logic [15:0] corners_left;
        logic [15:0] item_counter;
        logic [15:0] held_corner_index;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:             PH_IDLE,
        byte_position:     4'd0,
        assembly_word:     32'd0,
        held_x:            32'd0,
        held_y:            32'd0,
        vertex_count:      16'd0,
        items_left:        16'd0,
        corners_left:      16'd0,
        item_counter:      16'd0,
        held_corner_index: 16'd0
    };

    // One output record
    typedef struct packed {
        logic [2:0]         record_kind;
        logic [15:0]        item_number;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        corner_total;
        logic [15:0]        corner_vertex;
        logic               last_corner;
    } record_t;

endpackage

[sv/mssp_if.sv]
interface mssp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output first_byte,
                    output final_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte,
                  input final_byte, output ready);
endinterface

interface mssp_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         record_kind;
    logic [15:0]        item_number;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [15:0]        corner_total;
    logic [15:0]        corner_vertex;
    logic               last_corner;

    modport source (output valid, output record_kind, output item_number,
                    output coord_x, output coord_y, output coord_z,
                    output corner_total, output corner_vertex,
                    output last_corner, input ready);
    modport sink (input valid, input record_kind, input item_number,
                  input coord_x, input coord_y, input coord_z,
                  input corner_total, input corner_vertex,
                  input last_corner, output ready);
endinterface

[sv/mssp_step.sv]
module mssp_step (
    input  mssp_pkg::parse_state_t state,
    input  logic [7:0]             data_byte,
    input  logic                   first_byte,
    input  logic                   final_byte,
    output mssp_pkg::parse_state_t state_next,
    output mssp_pkg::record_t      record,
    output logic                   record_valid
);

    mssp_pkg::parse_state_t cur;
    mssp_pkg::parse_state_t nxt;
    mssp_pkg::record_t      rec;
    logic                   rec_valid;
    logic                   active;
    logic [3:0]             pos;
    logic [15:0]            word16;
    logic [31:0]            asm_word;
    logic [15:0]            items_dec;
    logic [15:0]            corners_dec;
    logic [15:0]            count_inc;

    // Start from reset state on a first byte
    always_comb
    begin
        cur    = first_byte ? mssp_pkg::STATE_RESET : state;
        active = first_byte || (state.phase != mssp_pkg::PH_IDLE);
        if (first_byte)
        begin
            cur.phase = mssp_pkg::PH_VCOUNT;
        end
    end

    // Assemble little-endian words
    always_comb
    begin
        pos    = cur.byte_position;
        word16 = pos[0] ? {data_byte, cur.assembly_word[7:0]} : {8'd0, data_byte};
        case (pos[1:0])
            2'd0:    asm_word = {24'd0, data_byte};
            2'd1:    asm_word = {cur.assembly_word[31:16], data_byte,
                                 cur.assembly_word[7:0]};
            2'd2:    asm_word = {cur.assembly_word[31:24], data_byte,
                                 cur.assembly_word[15:0]};
            default: asm_word = {data_byte, cur.assembly_word[23:0]};
        endcase
        items_dec   = cur.items_left - 16'd1;
        corners_dec = cur.corners_left - 16'd1;
        count_inc   = cur.item_counter + 16'd1;
    end

    // Advance the parse by one byte
    always_comb
    begin
        nxt               = cur;
        rec               = '0;
        rec_valid         = 1'b0;
        nxt.byte_position = pos + 4'd1;
        case (cur.phase)
            mssp_pkg::PH_VCOUNT:
            begin
                nxt.assembly_word = {16'd0, word16};
                if (pos >= 4'd1)
                begin
                    nxt.byte_position = 4'd0;
                    nxt.vertex_count  = word16;
                    nxt.items_left    = word16;
                    nxt.item_counter  = 16'd0;
                    nxt.phase = (word16 == 16'd0) ? mssp_pkg::PH_FCOUNT
                                                  : mssp_pkg::PH_VERT;
                end
            end
            mssp_pkg::PH_VERT:
            begin
                nxt.assembly_word = asm_word;
                if (pos == mssp_pkg::POS_X_LAST)
                begin
                    nxt.held_x = asm_word;
                end
                else if (pos == mssp_pkg::POS_Y_LAST)
                begin
                    nxt.held_y = asm_word;
                end
                else if (pos >= mssp_pkg::POS_VALS_LAST)
                begin
                    nxt.byte_position = 4'd0;
                    rec.record_kind   = mssp_pkg::KIND_VERTEX;
                    rec.item_number   = cur.item_counter;
                    rec.coord_x       = cur.held_x;
                    rec.coord_y       = cur.held_y;
                    rec.coord_z       = asm_word;
                    rec_valid         = 1'b1;
                    nxt.item_counter  = count_inc;
                    nxt.items_left    = items_dec;
                    if (items_dec == 16'd0)
                    begin
                        nxt.phase = mssp_pkg::PH_FCOUNT;
                    end
                end
            end
            mssp_pkg::PH_FCOUNT:
            begin
                nxt.assembly_word = {16'd0, word16};
                if (pos >= 4'd1)
                begin
                    nxt.byte_position = 4'd0;
                    nxt.items_left    = word16;
                    nxt.item_counter  = 16'd0;
                    nxt.phase = (word16 == 16'd0) ? mssp_pkg::PH_NPCOUNT
                                                  : mssp_pkg::PH_FHEAD;
                end
            end
            mssp_pkg::PH_FHEAD:
            begin
                nxt.assembly_word = {16'd0, word16};
                if (pos >= mssp_pkg::POS_FHEAD_LAST)
                begin
                    nxt.byte_position = 4'd0;
                    nxt.corners_left  = word16;
                    rec.record_kind   = mssp_pkg::KIND_FACE;
                    rec.item_number   = cur.item_counter;
                    rec.corner_total  = word16;
                    rec_valid         = 1'b1;
                    if (word16 == 16'd0)
                    begin
                        nxt.item_counter = count_inc;
                        nxt.items_left   = items_dec;
                        nxt.phase = (items_dec == 16'd0) ? mssp_pkg::PH_NPCOUNT
                                                         : mssp_pkg::PH_FHEAD;
                    end
                    else
                    begin
                        nxt.phase = mssp_pkg::PH_CORNER;
                    end
                end
            end
            mssp_pkg::PH_CORNER:
            begin
                if (pos <= 4'd1)
                begin
                    nxt.assembly_word = {16'd0, word16};
                    if (pos == 4'd1)
                    begin
                        nxt.held_corner_index = word16;
                    end
                end
                else if (pos >= mssp_pkg::POS_CORNER_LAST)
                begin
                    nxt.byte_position = 4'd0;
                    rec.item_number   = cur.item_counter;
                    rec.corner_vertex = cur.held_corner_index;
                    rec_valid         = 1'b1;
                    if (cur.held_corner_index >= cur.vertex_count)
                    begin
                        rec.record_kind = mssp_pkg::KIND_BADIDX;
                        nxt.phase       = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        rec.record_kind  = mssp_pkg::KIND_CORNER;
                        rec.last_corner  = (cur.corners_left == 16'd1);
                        nxt.corners_left = corners_dec;
                        if (corners_dec == 16'd0)
                        begin
                            nxt.item_counter = count_inc;
                            nxt.items_left   = items_dec;
                            nxt.phase = (items_dec == 16'd0) ? mssp_pkg::PH_NPCOUNT
                                                             : mssp_pkg::PH_FHEAD;
                        end
                    end
                end
            end
            mssp_pkg::PH_NPCOUNT:
            begin
                nxt.assembly_word = {16'd0, word16};
                if (pos >= 4'd1)
                begin
                    nxt.byte_position = 4'd0;
                    nxt.items_left    = word16;
                    if (word16 == 16'd0)
                    begin
                        rec.record_kind = mssp_pkg::KIND_DONE;
                        rec_valid       = 1'b1;
                        nxt.phase       = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        nxt.phase = mssp_pkg::PH_NPNAME;
                    end
                end
            end
            mssp_pkg::PH_NPNAME:
            begin
                nxt.byte_position = 4'd0;
                if (data_byte == 8'd0)
                begin
                    nxt.phase = mssp_pkg::PH_NPVALS;
                end
            end
            mssp_pkg::PH_NPVALS:
            begin
                if (pos >= mssp_pkg::POS_VALS_LAST)
                begin
                    nxt.byte_position = 4'd0;
                    nxt.items_left    = items_dec;
                    if (items_dec == 16'd0)
                    begin
                        rec.record_kind = mssp_pkg::KIND_DONE;
                        rec_valid       = 1'b1;
                        nxt.phase       = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        nxt.phase = mssp_pkg::PH_NPNAME;
                    end
                end
            end
            default:
            begin
                nxt.phase         = mssp_pkg::PH_IDLE;
                nxt.byte_position = 4'd0;
            end
        endcase

        // Truncate when the buffer ends mid-section
        if (final_byte && (nxt.phase != mssp_pkg::PH_IDLE))
        begin
            rec               = '0;
            rec.record_kind   = mssp_pkg::KIND_TRUNC;
            rec_valid         = 1'b1;
            nxt.phase         = mssp_pkg::PH_IDLE;
            nxt.byte_position = 4'd0;
        end
    end

    // Bytes while idle leave everything alone
    assign state_next   = active ? nxt : state;
    assign record       = rec;
    assign record_valid = active && rec_valid;

endmodule

[sv/mesh_section_stream_parser_unit.sv]
// A record appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle; each byte updates the parse state in a single
// combinational step. A record left waiting on the output stalls the input until taken.
// Reset: rst_n (asynchronous, active low) returns the parser to idle, waiting for a
// first byte, and empties the output register.
module mesh_section_stream_parser_unit (
    input logic              clk,
    input logic              rst_n,
    mssp_in_if.sink          byte_in,
    mssp_out_if.source       rec_out
);

    mssp_pkg::parse_state_t state_reg;
    mssp_pkg::parse_state_t state_next;
    mssp_pkg::record_t      record_reg;
    mssp_pkg::record_t      step_record;
    logic                   step_record_valid;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   accept;

    // Take a byte whenever the output register is free or draining
    assign byte_in.ready = !out_valid_reg || rec_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    mssp_step u_step (
        .state        (state_reg),
        .data_byte    (byte_in.data_byte),
        .first_byte   (byte_in.first_byte),
        .final_byte   (byte_in.final_byte),
        .state_next   (state_next),
        .record       (step_record),
        .record_valid (step_record_valid)
    );

    // Hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mssp_pkg::STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output valid: set by a new record, drop when taken
    always_comb
    begin
        if (accept && step_record_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rec_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the record payload
    always_ff @(posedge clk)
    begin
        if (accept && step_record_valid)
        begin
            record_reg <= step_record;
        end
    end

    assign rec_out.valid         = out_valid_reg;
    assign rec_out.record_kind   = record_reg.record_kind;
    assign rec_out.item_number   = record_reg.item_number;
    assign rec_out.coord_x       = record_reg.coord_x;
    assign rec_out.coord_y       = record_reg.coord_y;
    assign rec_out.coord_z       = record_reg.coord_z;
    assign rec_out.corner_total  = record_reg.corner_total;
    assign rec_out.corner_vertex = record_reg.corner_vertex;
    assign rec_out.last_corner   = record_reg.last_corner;

endmodule

[tb/mssp_checker.sv]
module mssp_checker (
    input  logic clk,
    input  logic rst_n,
    mssp_in_if   byte_mon,
    mssp_out_if  rec_mon,
    output int   fail_count,
    output int   outstanding
);

    // Byte positions that close each field group
    localparam logic [3:0] BYTE_X_END      = 4'd3;
    localparam logic [3:0] BYTE_Y_END      = 4'd7;
    localparam logic [3:0] BYTE_VERT_END   = 4'd11;
    localparam logic [3:0] BYTE_FHEAD_END  = 4'd3;
    localparam logic [3:0] BYTE_CORNER_END = 4'd9;
    localparam logic [3:0] BYTE_POINT_END  = 4'd11;

    mssp_pkg::parse_state_t walk;
    mssp_pkg::record_t      expected_recs[$];

    task automatic report_mismatch(input string msg);
        $display("mssp_checker: %0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic field_check(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    // Count the face as done and move to the next face or to the named points
    task automatic close_face();
        walk.item_counter = walk.item_counter + 16'd1;
        walk.items_left   = walk.items_left - 16'd1;
        walk.phase        = (walk.items_left == 16'd0) ? mssp_pkg::PH_NPCOUNT
                                                       : mssp_pkg::PH_FHEAD;
    endtask

    // Advance the parse by one byte and work out the record it gives, if any
    task automatic advance_parse(input logic [7:0] data, input logic opens,
                                 input logic closes, output bit emits,
                                 output mssp_pkg::record_t rec);
        logic [3:0]  pos;
        logic [15:0] word16;
        emits = 1'b0;
        rec   = '0;
        if (opens)
        begin
            walk       = mssp_pkg::STATE_RESET;
            walk.phase = mssp_pkg::PH_VCOUNT;
        end
        else if (walk.phase == mssp_pkg::PH_IDLE)
        begin
            return;
        end

        pos    = walk.byte_position;
        word16 = pos[0] ? {data, walk.assembly_word[7:0]} : {8'h00, data};
        walk.byte_position = pos + 4'd1;

        case (walk.phase)
            mssp_pkg::PH_VCOUNT:
            begin
                walk.assembly_word = {16'h0000, word16};
                if (pos >= 4'd1)
                begin
                    walk.byte_position = '0;
                    walk.vertex_count  = word16;
                    walk.items_left    = word16;
                    walk.item_counter  = '0;
                    walk.phase = (word16 == 16'd0) ? mssp_pkg::PH_FCOUNT
                                                   : mssp_pkg::PH_VERT;
                end
            end
            mssp_pkg::PH_VERT:
            begin
                if (pos[1:0] == 2'd0)
                begin
                    walk.assembly_word = {24'h000000, data};
                end
                else
                begin
                    walk.assembly_word = walk.assembly_word
                                       | ({24'h000000, data} << (8 * pos[1:0]));
                end
                if (pos == BYTE_X_END)
                begin
                    walk.held_x = walk.assembly_word;
                end
                else if (pos == BYTE_Y_END)
                begin
                    walk.held_y = walk.assembly_word;
                end
                else if (pos >= BYTE_VERT_END)
                begin
                    walk.byte_position = '0;
                    rec.record_kind    = mssp_pkg::KIND_VERTEX;
                    rec.item_number    = walk.item_counter;
                    rec.coord_x        = walk.held_x;
                    rec.coord_y        = walk.held_y;
                    rec.coord_z        = walk.assembly_word;
                    emits              = 1'b1;
                    walk.item_counter  = walk.item_counter + 16'd1;
                    walk.items_left    = walk.items_left - 16'd1;
                    if (walk.items_left == 16'd0)
                    begin
                        walk.phase = mssp_pkg::PH_FCOUNT;
                    end
                end
            end
            mssp_pkg::PH_FCOUNT:
            begin
                walk.assembly_word = {16'h0000, word16};
                if (pos >= 4'd1)
                begin
                    walk.byte_position = '0;
                    walk.items_left    = word16;
                    walk.item_counter  = '0;
                    walk.phase = (word16 == 16'd0) ? mssp_pkg::PH_NPCOUNT
                                                   : mssp_pkg::PH_FHEAD;
                end
            end
            mssp_pkg::PH_FHEAD:
            begin
                walk.assembly_word = {16'h0000, word16};
                if (pos >= BYTE_FHEAD_END)
                begin
                    walk.byte_position = '0;
                    walk.corners_left  = word16;
                    rec.record_kind    = mssp_pkg::KIND_FACE;
                    rec.item_number    = walk.item_counter;
                    rec.corner_total   = word16;
                    emits              = 1'b1;
                    if (word16 == 16'd0)
                    begin
                        close_face();
                    end
                    else
                    begin
                        walk.phase = mssp_pkg::PH_CORNER;
                    end
                end
            end
            mssp_pkg::PH_CORNER:
            begin
                if (pos <= 4'd1)
                begin
                    walk.assembly_word = {16'h0000, word16};
                    if (pos == 4'd1)
                    begin
                        walk.held_corner_index = word16;
                    end
                end
                else if (pos >= BYTE_CORNER_END)
                begin
                    walk.byte_position = '0;
                    rec.item_number    = walk.item_counter;
                    rec.corner_vertex  = walk.held_corner_index;
                    emits              = 1'b1;
                    // Check the index only once U and V are in
                    if (walk.held_corner_index >= walk.vertex_count)
                    begin
                        rec.record_kind = mssp_pkg::KIND_BADIDX;
                        walk.phase      = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        rec.record_kind   = mssp_pkg::KIND_CORNER;
                        rec.last_corner   = (walk.corners_left == 16'd1);
                        walk.corners_left = walk.corners_left - 16'd1;
                        if (walk.corners_left == 16'd0)
                        begin
                            close_face();
                        end
                    end
                end
            end
            mssp_pkg::PH_NPCOUNT:
            begin
                walk.assembly_word = {16'h0000, word16};
                if (pos >= 4'd1)
                begin
                    walk.byte_position = '0;
                    walk.items_left    = word16;
                    if (word16 == 16'd0)
                    begin
                        rec.record_kind = mssp_pkg::KIND_DONE;
                        emits           = 1'b1;
                        walk.phase      = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        walk.phase = mssp_pkg::PH_NPNAME;
                    end
                end
            end
            mssp_pkg::PH_NPNAME:
            begin
                walk.byte_position = '0;
                if (data == 8'h00)
                begin
                    walk.phase = mssp_pkg::PH_NPVALS;
                end
            end
            mssp_pkg::PH_NPVALS:
            begin
                if (pos >= BYTE_POINT_END)
                begin
                    walk.byte_position = '0;
                    walk.items_left    = walk.items_left - 16'd1;
                    if (walk.items_left == 16'd0)
                    begin
                        rec.record_kind = mssp_pkg::KIND_DONE;
                        emits           = 1'b1;
                        walk.phase      = mssp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        walk.phase = mssp_pkg::PH_NPNAME;
                    end
                end
            end
            default:
            begin
                walk.phase         = mssp_pkg::PH_IDLE;
                walk.byte_position = '0;
            end
        endcase

        // Replace any record but done and bad index when the buffer runs dry
        if (closes && walk.phase != mssp_pkg::PH_IDLE)
        begin
            rec                = '0;
            rec.record_kind    = mssp_pkg::KIND_TRUNC;
            emits              = 1'b1;
            walk.phase         = mssp_pkg::PH_IDLE;
            walk.byte_position = '0;
        end
    endtask

    always @(posedge clk)
    begin : watch
        mssp_pkg::record_t got;
        mssp_pkg::record_t want;
        mssp_pkg::record_t next_rec;
        bit                emits;
        if (!rst_n)
        begin
            walk = mssp_pkg::STATE_RESET;
            expected_recs.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare the record leaving the block before predicting new ones
            if (rec_mon.valid && rec_mon.ready)
            begin
                got.record_kind   = rec_mon.record_kind;
                got.item_number   = rec_mon.item_number;
                got.coord_x       = rec_mon.coord_x;
                got.coord_y       = rec_mon.coord_y;
                got.coord_z       = rec_mon.coord_z;
                got.corner_total  = rec_mon.corner_total;
                got.corner_vertex = rec_mon.corner_vertex;
                got.last_corner   = rec_mon.last_corner;
                if (expected_recs.size() == 0)
                begin
                    report_mismatch($sformatf("record kind %0d with none expected",
                                              got.record_kind));
                end
                else
                begin
                    want = expected_recs.pop_front();
                    field_check("record_kind", 32'(got.record_kind), 32'(want.record_kind));
                    field_check("item_number", 32'(got.item_number), 32'(want.item_number));
                    field_check("coord_x", got.coord_x, want.coord_x);
                    field_check("coord_y", got.coord_y, want.coord_y);
                    field_check("coord_z", got.coord_z, want.coord_z);
                    field_check("corner_total", 32'(got.corner_total),
                                32'(want.corner_total));
                    field_check("corner_vertex", 32'(got.corner_vertex),
                                32'(want.corner_vertex));
                    field_check("last_corner", 32'(got.last_corner), 32'(want.last_corner));
                end
            end
            // Predict from the byte entering the block
            if (byte_mon.valid && byte_mon.ready)
            begin
                advance_parse(byte_mon.data_byte, byte_mon.first_byte, byte_mon.final_byte,
                              emits, next_rec);
                if (emits)
                begin
                    expected_recs.insert(expected_recs.size(), next_rec);
                end
            end
            outstanding <= expected_recs.size();
        end
    end

endmodule

[tb/tb_top.sv]
module tb_top;

    typedef struct packed {
        logic [7:0] data;
        logic       opens;
        logic       closes;
    } stream_byte_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   long_hold_req;

    stream_byte_t byte_plan[$];
    logic [7:0]   section[$];

    mssp_in_if  byte_ch ();
    mssp_out_if rec_ch ();

    mesh_section_stream_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .rec_out (rec_ch)
    );

    mssp_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_mon    (byte_ch),
        .rec_mon     (rec_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Drain records, idling at random; hold off once for a long stretch
    initial
    begin : rec_drain
        int hold_left;
        bit hold_served;
        hold_left     = 0;
        hold_served   = 1'b0;
        rec_ch.ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                hold_left   = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rec_ch.ready <= 1'b0;
            end
            else
            begin
                rec_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_plan(input logic [7:0] data, input logic opens, input logic closes);
        byte_plan.insert(byte_plan.size(), '{data: data, opens: opens, closes: closes});
    endtask

    task automatic push16(input logic [15:0] v);
        section.insert(section.size(), v[7:0]);
        section.insert(section.size(), v[15:8]);
    endtask

    task automatic push32(input logic [31:0] v);
        push16(v[15:0]);
        push16(v[31:16]);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(15))
            0:       return 32'h80000000;
            1:       return 32'h7FFFFFFF;
            2:       return 32'hFFFFFFFF;
            3:       return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    // Move the built section into the plan, marking its first and maybe its last byte
    task automatic emit_section(input logic closes);
        foreach (section[i])
        begin
            push_plan(section[i], i == 0, closes && (i == section.size() - 1));
        end
    endtask

    // Build a small section with random content
    task automatic compose_section();
        int nv;
        int nf;
        int nc;
        int np;
        section.delete();
        nv = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
        push16(16'(nv));
        repeat (nv * 3) push32(pick_coord());
        nf = $urandom_range(3);
        push16(16'(nf));
        repeat (nf)
        begin
            push16(16'($urandom));
            nc = $urandom_range(3);
            push16(16'(nc));
            repeat (nc)
            begin
                // Mostly good indexes; now and then one at or past the vertex count
                if (nv > 0 && $urandom_range(24) != 0)
                begin
                    push16(16'($urandom_range(nv - 1, 0)));
                end
                else
                begin
                    push16(16'($urandom_range(65535, nv)));
                end
                push32($urandom);
                push32($urandom);
            end
        end
        np = $urandom_range(2);
        push16(16'(np));
        repeat (np)
        begin
            repeat ($urandom_range(3))
                section.insert(section.size(), 8'($urandom_range(255, 1)));
            section.insert(section.size(), 8'h00);
            repeat (3) push32($urandom);
        end
    endtask

    // Queue a whole section, or one cut short at a random byte (sometimes with its vertex count set to 0xFFFF)
    task automatic queue_section(input bit broken, inout int counted);
        int cut;
        compose_section();
        if (broken)
        begin
            if ($urandom_range(3) == 0)
            begin
                section[0] = 8'hFF;
                section[1] = 8'hFF;
            end
            cut = $urandom_range(section.size() - 1, 1);
            section = section[0:cut - 1];
            emit_section($urandom_range(9) < 7);
        end
        else
        begin
            emit_section(1'($urandom_range(1)));
        end
        counted += section.size();
    endtask

    // Offer every planned byte, idling at random between them
    task automatic play_plan();
        stream_byte_t b;
        while (byte_plan.size() > 0)
        begin
            b = byte_plan.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
            end
            byte_ch.valid      <= 1'b1;
            byte_ch.data_byte  <= b.data;
            byte_ch.first_byte <= b.opens;
            byte_ch.final_byte <= b.closes;
            do
                @(posedge clk);
            while (!byte_ch.ready);
        end
    endtask

    // Hold the input until every predicted record has come out
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        int counted;
        int pick;
        rst_n              = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.data_byte  = 8'h00;
        byte_ch.first_byte = 1'b0;
        byte_ch.final_byte = 1'b0;
        long_hold_req      = 1'b0;
        send_idle_pct      = 6;
        recv_idle_pct      = 87;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Stray byte while idle, an empty section ending on the last byte,
        // and a corner whose index is past an empty vertex list
        push_plan(8'hA5, 1'b0, 1'b0);
        section.delete();
        repeat (3) push16(16'h0000);
        emit_section(1'b1);
        section.delete();
        push16(16'h0000);
        push16(16'h0001);
        push16(16'h1234);
        push16(16'h0001);
        push16(16'hFFFF);
        push32(32'h80000000);
        push32(32'h7FFFFFFF);
        emit_section(1'b0);
        play_plan();
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 6;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    long_hold_req = 1'b1;
                end
            endcase
            counted = 0;
            while (counted < 470)
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    queue_section(1'b0, counted);
                end
                else if (pick < 85)
                begin
                    queue_section(1'b1, counted);
                end
                else
                begin
                    // Noise: mostly bytes dropped while idle, now and then a false start
                    repeat ($urandom_range(6, 1))
                    begin
                        push_plan(8'($urandom), $urandom_range(15) == 0,
                                  1'($urandom_range(1)));
                    end
                end
            end
            play_plan();
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
